// ===== src/bcb_pkg.sv =====
// ----------------------------------------------------------------------------
// bcb_pkg
// Types, codes and helpers shared by the backoff circuit breaker modules.
// ----------------------------------------------------------------------------
package bcb_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register indexes (byte address / 4)
   localparam logic [2:0] CSR_COOLDOWN_STEP   = 3'd0;
   localparam logic [2:0] CSR_COOLDOWN_CAP    = 3'd1;
   localparam logic [2:0] CSR_DORMANT_PERIOD  = 3'd2;
   localparam logic [2:0] CSR_CPU_LIMIT       = 3'd3;
   localparam logic [2:0] CSR_BACKEND_LIMIT   = 3'd4;
   localparam logic [2:0] CSR_DISK_FREE_MIN   = 3'd5;

   // Register values after reset
   localparam logic [15:0] COOLDOWN_STEP_RST  = 16'd30;
   localparam logic [15:0] COOLDOWN_CAP_RST   = 16'd600;
   localparam logic [15:0] DORMANT_PERIOD_RST = 16'd600;
   localparam logic [9:0]  CPU_LIMIT_RST      = 10'd900;
   localparam logic [9:0]  BACKEND_LIMIT_RST  = 10'd900;
   localparam logic [6:0]  DISK_FREE_MIN_RST  = 7'd5;

   // Request codes
   localparam logic [1:0] REQ_CHECK   = 2'd0;
   localparam logic [1:0] REQ_SUCCESS = 2'd1;
   localparam logic [1:0] REQ_SKIP    = 2'd2;

   // Breaker state codes as seen on the result item
   localparam logic [1:0] STATE_CLOSED  = 2'd0;
   localparam logic [1:0] STATE_OPEN    = 2'd1;
   localparam logic [1:0] STATE_DORMANT = 2'd2;

   localparam logic [7:0] OPEN_TO_DORMANT_SKIPS   = 8'd6;
   localparam logic [7:0] CLOSED_TO_OPEN_SKIPS    = 8'd3;
   localparam logic [7:0] DORMANT_CLOSE_SUCCESSES = 8'd3;
   localparam logic [7:0] COUNT_MAX               = 8'd255;

   typedef enum logic [2:0] {
      MODE_CLOSED  = 3'b001,
      MODE_OPEN    = 3'b010,
      MODE_DORMANT = 3'b100
   } mode_type;

   typedef enum logic [2:0] {
      REASON_CLEAR    = 3'd0,
      REASON_ESTOP    = 3'd1,
      REASON_COOLDOWN = 3'd2,
      REASON_DORMANT  = 3'd3,
      REASON_CPU      = 3'd4,
      REASON_BACKENDS = 3'd5,
      REASON_DISK     = 3'd6,
      REASON_RECORD   = 3'd7
   } reason_type;

   typedef struct packed {
      logic [15:0] cooldown_step_sec;
      logic [15:0] cooldown_cap_sec;
      logic [15:0] dormant_period_sec;
      logic [9:0]  cpu_limit_tenths;
      logic [9:0]  backend_limit_permille;
      logic [6:0]  disk_free_min_pct;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_sec;
      logic [31:0] last_collect_sec;
      logic        emergency_stop;
      logic        cpu_valid;
      logic [9:0]  cpu_load_tenths;
      logic [9:0]  backend_ratio_permille;
      logic        disk_valid;
      logic [9:0]  disk_free_tenths;
   } req_item_type;

   typedef struct packed {
      logic       allowed;
      logic [2:0] reason;
      logic [1:0] breaker_state;
      logic       state_changed;
      logic [7:0] skip_count_out;
      logic [7:0] success_count_out;
   } rsp_item_type;

   function automatic logic [1:0] mode_code(input mode_type mode);
      logic [1:0] code;
      unique case (mode)
         MODE_OPEN:    code = STATE_OPEN;
         MODE_DORMANT: code = STATE_DORMANT;
         default:      code = STATE_CLOSED;
      endcase
      return code;
   endfunction

endpackage

// ===== src/bcb_csr.sv =====
// ----------------------------------------------------------------------------
// bcb_csr
// APB-style configuration registers of the backoff circuit breaker.
// ----------------------------------------------------------------------------
module bcb_csr
   import bcb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_COOLDOWN_STEP:  cfg_in.cooldown_step_sec      = pwdata[15:0];
            CSR_COOLDOWN_CAP:   cfg_in.cooldown_cap_sec       = pwdata[15:0];
            CSR_DORMANT_PERIOD: cfg_in.dormant_period_sec     = pwdata[15:0];
            CSR_CPU_LIMIT:      cfg_in.cpu_limit_tenths       = pwdata[9:0];
            CSR_BACKEND_LIMIT:  cfg_in.backend_limit_permille = pwdata[9:0];
            CSR_DISK_FREE_MIN:  cfg_in.disk_free_min_pct      = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cooldown_step_sec      <= COOLDOWN_STEP_RST;
         cfg_ff.cooldown_cap_sec       <= COOLDOWN_CAP_RST;
         cfg_ff.dormant_period_sec     <= DORMANT_PERIOD_RST;
         cfg_ff.cpu_limit_tenths       <= CPU_LIMIT_RST;
         cfg_ff.backend_limit_permille <= BACKEND_LIMIT_RST;
         cfg_ff.disk_free_min_pct      <= DISK_FREE_MIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_COOLDOWN_STEP:  prdata = {16'd0, cfg_ff.cooldown_step_sec};
         CSR_COOLDOWN_CAP:   prdata = {16'd0, cfg_ff.cooldown_cap_sec};
         CSR_DORMANT_PERIOD: prdata = {16'd0, cfg_ff.dormant_period_sec};
         CSR_CPU_LIMIT:      prdata = {22'd0, cfg_ff.cpu_limit_tenths};
         CSR_BACKEND_LIMIT:  prdata = {22'd0, cfg_ff.backend_limit_permille};
         CSR_DISK_FREE_MIN:  prdata = {25'd0, cfg_ff.disk_free_min_pct};
         default:            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/bcb_engine.sv =====
// ----------------------------------------------------------------------------
// bcb_engine
// Breaker state, skip and success counters, and the decision logic for one
// request. State advances on the cycle the item leaves the input register.
// ----------------------------------------------------------------------------
module bcb_engine
   import bcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   mode_type    mode_ff;
   mode_type    mode_in;
   logic [7:0]  skip_ff;
   logic [7:0]  skip_in;
   logic [7:0]  succ_ff;
   logic [7:0]  succ_in;

   logic [32:0] diff;
   logic [31:0] elapsed;
   logic [7:0]  mult;
   logic [23:0] cool;
   logic        cool_done;
   logic [10:0] disk_thr;
   logic [7:0]  skip_inc;
   logic [7:0]  succ_inc;
   reason_type  reason;
   logic        allowed;

   // Elapsed time, clamped at zero when the clock appears to run backwards
   assign diff    = {1'b0, item.now_sec} - {1'b0, item.last_collect_sec};
   assign elapsed = diff[32] ? 32'd0 : diff[31:0];

   assign mult      = (skip_ff == 8'd0) ? 8'd1 : skip_ff;
   assign cool      = 24'(cfg.cooldown_step_sec) * 24'(mult);
   // elapsed >= min(cool, cap) split into two parallel compares
   assign cool_done = (elapsed >= {8'd0, cool}) ||
                      (elapsed >= {16'd0, cfg.cooldown_cap_sec});
   assign disk_thr  = 11'({cfg.disk_free_min_pct, 3'b000}) +
                      11'({cfg.disk_free_min_pct, 1'b0});

   assign skip_inc = (skip_ff == COUNT_MAX) ? skip_ff : skip_ff + 8'd1;
   assign succ_inc = (succ_ff == COUNT_MAX) ? succ_ff : succ_ff + 8'd1;

   always_comb begin
      mode_in = mode_ff;
      skip_in = skip_ff;
      succ_in = succ_ff;
      allowed = 1'b0;
      reason  = REASON_RECORD;
      unique case (item.req_type)
         REQ_CHECK: begin
            if (item.emergency_stop) begin
               reason = REASON_ESTOP;
            end else begin
               unique case (mode_ff)
                  MODE_OPEN: begin
                     if (cool_done) begin
                        mode_in = MODE_CLOSED;
                        allowed = 1'b1;
                        reason  = REASON_CLEAR;
                     end else begin
                        reason = REASON_COOLDOWN;
                     end
                  end
                  MODE_DORMANT: begin
                     if (elapsed < {16'd0, cfg.dormant_period_sec}) begin
                        reason = REASON_DORMANT;
                     end else begin
                        allowed = 1'b1;
                        reason  = REASON_CLEAR;
                     end
                  end
                  default: begin
                     priority if (item.cpu_valid &&
                                  item.cpu_load_tenths > cfg.cpu_limit_tenths) begin
                        reason = REASON_CPU;
                     end else if (!item.cpu_valid &&
                                  item.backend_ratio_permille >
                                  cfg.backend_limit_permille) begin
                        reason = REASON_BACKENDS;
                     end else if (item.disk_valid &&
                                  {1'b0, item.disk_free_tenths} < disk_thr) begin
                        reason = REASON_DISK;
                     end else begin
                        allowed = 1'b1;
                        reason  = REASON_CLEAR;
                     end
                  end
               endcase
            end
         end
         REQ_SUCCESS: begin
            skip_in = 8'd0;
            succ_in = succ_inc;
            priority if (mode_ff == MODE_DORMANT &&
                         succ_inc >= DORMANT_CLOSE_SUCCESSES) begin
               mode_in = MODE_CLOSED;
            end else if (mode_ff == MODE_OPEN) begin
               mode_in = MODE_CLOSED;
            end else begin
               mode_in = mode_ff;
            end
         end
         REQ_SKIP: begin
            succ_in = 8'd0;
            skip_in = skip_inc;
            priority if (mode_ff == MODE_OPEN &&
                         skip_inc >= OPEN_TO_DORMANT_SKIPS) begin
               mode_in = MODE_DORMANT;
            end else if (mode_ff == MODE_CLOSED &&
                         skip_inc >= CLOSED_TO_OPEN_SKIPS) begin
               mode_in = MODE_OPEN;
            end else begin
               mode_in = mode_ff;
            end
         end
         default: ;  // unknown request: state and counters held
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CLOSED;
         skip_ff <= 8'd0;
         succ_ff <= 8'd0;
      end else if (fire) begin
         mode_ff <= mode_in;
         skip_ff <= skip_in;
         succ_ff <= succ_in;
      end
   end

   always_comb begin
      result.allowed           = allowed;
      result.reason            = reason;
      result.breaker_state     = mode_code(mode_in);
      result.state_changed     = (mode_in != mode_ff);
      result.skip_count_out    = skip_in;
      result.success_count_out = succ_in;
   end

   a_check_keeps_counts: assert property (@(posedge clock) disable iff (reset)
      fire && item.req_type == REQ_CHECK |=>
         skip_ff == $past(skip_ff) && succ_ff == $past(succ_ff))
      else $error("check item altered the counters");

   a_success_clears_skips: assert property (@(posedge clock) disable iff (reset)
      fire && item.req_type == REQ_SUCCESS |=> skip_ff == 8'd0 && succ_ff != 8'd0)
      else $error("success item did not clear skips or count success");

   a_no_closed_to_dormant: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_CLOSED |=> mode_ff != MODE_DORMANT)
      else $error("breaker went from closed to dormant in one item");

endmodule

// ===== src/backoff_circuit_breaker.sv =====
// ----------------------------------------------------------------------------
// backoff_circuit_breaker
// Three-state breaker (closed, open, dormant) with linear, capped backoff.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel (req_valid / req_ready / req_item):
//   a check, a record of success or a record of a skip. Every item gives
//   exactly one result on the rsp_ channel (rsp_valid / rsp_ready / rsp_item)
//   with the decision, the reason, the breaker state and both counters.
//   The item sits in the input register, then the decision logic and the
//   breaker state update feed the result register. Throughput is one item
//   per cycle while the receiver keeps rsp_ready high; the breaker state
//   is updated as each item moves on, so back-to-back items see each
//   other's updates.
//   The limits are set through the APB-style port (psel, penable, pwrite,
//   paddr, pwdata, prdata, pready), one register per word; write them only
//   while no item is in flight.
//   Reset (synchronous, active high) closes the breaker, clears both
//   counters, restores the register defaults and empties the pipeline.
//   When the receiver stalls, the result is held and the input register
//   keeps one more item; req_ready drops once both stages are full.
// ----------------------------------------------------------------------------
module backoff_circuit_breaker
   import bcb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_item_type              req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_item_type              rsp_item,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type      cfg;
   req_item_type in_item_ff;
   logic         in_valid_ff;
   logic         in_valid_in;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type result;
   logic         req_fire;
   logic         advance;

   bcb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bcb_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Move an item on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_held_item_stays: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && in_item_ff == $past(in_item_ff))
      else $error("stalled item lost from input register");

   a_result_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without an item moving on");

endmodule
